FILE: rtl/eat_pkg.sv
// Package for the elitist archive table: operation codes, result status codes
// and the sequencer state type. It has no dependencies.
package eat_pkg;

  localparam logic [1:0] MODE_OFFER  = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_REPLACED = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_BEST     = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_DECIDE
  } state_t;

endpackage

FILE: rtl/elitist_archive_table_unit.sv
// Top level of the elitist archive table: slot memories, scan sequencer,
// shared fitness comparator and result register. Depends on eat_pkg.
//
// Channel | Handshake            | Fields
// --------+----------------------+-------------------------------------------------------------
// in      | in_valid, in_stall   | mode, sender_robot, sender_generation, offered_fitness/handle
// out     | out_valid, out_stall | status, best_robot/generation/handle/fitness, entry_count
// cfg     | cfg_we               | cfg_wdata (capacity)
//
// An offer or a select scans every slot after acceptance, one memory read per slot through
// the single read port, then drains the read register in the flush state and decides and
// writes back in the decision state. A clear or an unused mode goes straight to the decision
// state. The input is free again in the cycle after the decision, so a new transaction is
// taken only once the previous one has left the decision state.
// Reset is synchronous; it empties the table and sets the capacity to 16.
// A new transaction is taken while the previous result waits; a stalled result only holds
// the block in its decision cycle.
module elitist_archive_table_unit #(
  parameter int TABLE_SLOTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [9:0]         sender_robot,
  input  logic [15:0]        sender_generation,
  input  logic signed [31:0] offered_fitness,
  input  logic [15:0]        offered_handle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [9:0]         best_robot,
  output logic [15:0]        best_generation,
  output logic [15:0]        best_handle,
  output logic signed [31:0] best_fitness,
  output logic [4:0]         entry_count
);
  import eat_pkg::*;

  localparam int SLOT_W  = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int COUNT_W = $clog2(TABLE_SLOTS + 1);
  localparam int CMP_W   = (COUNT_W > 5) ? COUNT_W : 5;

  state_t state, state_next;

  logic [4:0]          capacity;
  logic [TABLE_SLOTS-1:0] slot_valid;
  logic [COUNT_W-1:0]  valid_count;

  logic [SLOT_W-1:0]   idx;
  logic                pipe_valid;
  logic [SLOT_W-1:0]   pipe_slot;

  logic [1:0]          op_mode;
  logic [9:0]          op_robot;
  logic [15:0]         op_gen;
  logic signed [31:0]  op_fit;
  logic [15:0]         op_handle;

  logic [9:0]          mem_robot [TABLE_SLOTS];
  logic [15:0]         mem_gen [TABLE_SLOTS];
  logic signed [31:0]  mem_fit [TABLE_SLOTS];
  logic [15:0]         mem_handle [TABLE_SLOTS];
  logic [9:0]          rd_robot;
  logic [15:0]         rd_gen;
  logic signed [31:0]  rd_fit;
  logic [15:0]         rd_handle;

  logic                match_found;
  logic [SLOT_W-1:0]   match_slot;
  logic                free_found;
  logic [SLOT_W-1:0]   free_slot;
  logic                ext_have;
  logic [SLOT_W-1:0]   ext_slot;
  logic signed [31:0]  ext_fit;
  logic [9:0]          ext_robot;
  logic [15:0]         ext_gen;
  logic [15:0]         ext_handle;

  logic                accept;
  logic                decide_fire;
  logic signed [31:0]  cmp_a;
  logic signed [31:0]  cmp_b;
  logic                cmp_lt;
  logic                pipe_live;
  logic                key_hit;
  logic                ext_take;
  logic [CMP_W-1:0]    eff_cap;
  logic                room;
  logic [2:0]          res_status;
  logic                do_update;
  logic                do_insert;
  logic                do_replace;
  logic                do_clear;
  logic [SLOT_W-1:0]   wr_slot;
  logic [COUNT_W-1:0]  count_after;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // One signed comparator serves the scan (minimum or maximum search) and the
  // replacement test in the decision cycle.
  always_comb begin
    if (state == S_DECIDE) begin
      cmp_a = op_fit;
      cmp_b = ext_fit;
    end else if (op_mode == MODE_SELECT) begin
      cmp_a = ext_fit;
      cmp_b = rd_fit;
    end else begin
      cmp_a = rd_fit;
      cmp_b = ext_fit;
    end
    cmp_lt = cmp_a < cmp_b;
  end

  assign pipe_live = pipe_valid && slot_valid[pipe_slot];
  assign key_hit   = (rd_robot == op_robot) && (rd_gen == op_gen);
  assign ext_take  = pipe_live && (!ext_have || cmp_lt);

  always_comb begin
    if (capacity == 5'd0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(TABLE_SLOTS)) begin
      eff_cap = CMP_W'(TABLE_SLOTS);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
    room = CMP_W'(valid_count) < eff_cap;
  end

  always_comb begin
    res_status = ST_REJECTED;
    do_update  = 1'b0;
    do_insert  = 1'b0;
    do_replace = 1'b0;
    do_clear   = 1'b0;
    unique case (op_mode)
      MODE_OFFER: begin
        priority if (match_found) begin
          res_status = ST_UPDATED;
          do_update  = 1'b1;
        end else if (room) begin
          res_status = ST_INSERTED;
          do_insert  = 1'b1;
        end else if (ext_have && !cmp_lt) begin
          res_status = ST_REPLACED;
          do_replace = 1'b1;
        end else begin
          res_status = ST_REJECTED;
        end
      end
      MODE_SELECT: begin
        res_status = ext_have ? ST_BEST : ST_EMPTY;
      end
      MODE_CLEAR: begin
        res_status = ST_CLEARED;
        do_clear   = 1'b1;
      end
      default: begin
        res_status = ST_REJECTED;
      end
    endcase

    priority if (do_insert) begin
      wr_slot = free_slot;
    end else if (do_replace) begin
      wr_slot = ext_slot;
    end else begin
      wr_slot = match_slot;
    end

    priority if (do_clear) begin
      count_after = '0;
    end else if (do_insert) begin
      count_after = valid_count + COUNT_W'(1);
    end else begin
      count_after = valid_count;
    end
  end

  assign decide_fire = (state == S_DECIDE) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (mode == MODE_OFFER || mode == MODE_SELECT) ? S_SCAN : S_DECIDE;
        end
      end
      S_SCAN: begin
        if (idx == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (decide_fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity    <= CAPACITY_RESET;
      slot_valid  <= '0;
      valid_count <= '0;
      pipe_valid  <= 1'b0;
      out_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      ext_have    <= 1'b0;
    end else begin
      state      <= state_next;
      pipe_valid <= (state == S_SCAN);
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        match_found <= 1'b0;
        free_found  <= 1'b0;
        ext_have    <= 1'b0;
      end else if (pipe_valid) begin
        if (pipe_live && key_hit && !match_found) begin
          match_found <= 1'b1;
        end
        if (!pipe_live && !free_found) begin
          free_found <= 1'b1;
        end
        if (ext_take) begin
          ext_have <= 1'b1;
        end
      end
      if (decide_fire) begin
        out_valid   <= 1'b1;
        valid_count <= count_after;
        if (do_clear) begin
          slot_valid <= '0;
        end else if (do_insert) begin
          slot_valid[free_slot] <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode   <= mode;
      op_robot  <= sender_robot;
      op_gen    <= sender_generation;
      op_fit    <= offered_fitness;
      op_handle <= offered_handle;
      idx       <= '0;
    end else if (state == S_SCAN) begin
      idx <= idx + SLOT_W'(1);
    end
    pipe_slot <= idx;
    if (pipe_valid) begin
      if (pipe_live && key_hit && !match_found) begin
        match_slot <= pipe_slot;
      end
      if (!pipe_live && !free_found) begin
        free_slot <= pipe_slot;
      end
      if (ext_take) begin
        ext_slot   <= pipe_slot;
        ext_fit    <= rd_fit;
        ext_robot  <= rd_robot;
        ext_gen    <= rd_gen;
        ext_handle <= rd_handle;
      end
    end
    if (decide_fire) begin
      status      <= res_status;
      entry_count <= 5'(count_after);
      if (op_mode == MODE_SELECT && ext_have) begin
        best_robot      <= ext_robot;
        best_generation <= ext_gen;
        best_handle     <= ext_handle;
        best_fitness    <= ext_fit;
      end else begin
        best_robot      <= '0;
        best_generation <= '0;
        best_handle     <= '0;
        best_fitness    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (decide_fire && (do_insert || do_replace)) begin
      mem_robot[wr_slot]  <= op_robot;
      mem_gen[wr_slot]    <= op_gen;
      mem_handle[wr_slot] <= op_handle;
    end
    if (decide_fire && (do_insert || do_replace || do_update)) begin
      mem_fit[wr_slot] <= op_fit;
    end
    rd_robot  <= mem_robot[idx];
    rd_gen    <= mem_gen[idx];
    rd_fit    <= mem_fit[idx];
    rd_handle <= mem_handle[idx];
  end

`ifndef ASSERT_OFF
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(slot_valid) == int'(valid_count))
    else $error("Entry count does not match the number of valid slots.");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    int'(valid_count) <= TABLE_SLOTS)
    else $error("Entry count exceeds the table size.");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    decide_fire && do_clear |=> (valid_count == '0) && (slot_valid == '0))
    else $error("A clear transaction left entries in the table.");

  a_best_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_BEST) |-> (best_fitness == '0) && (best_robot == '0))
    else $error("Best-entry fields are set on a result that is not a selection.");
`endif

endmodule

FILE: tb/sv/elitist_archive_table_unit_tb.sv
// Self-checking testbench for elitist_archive_table_unit: a directed table and random
// offers, selects, clears and unused modes, checked against the table's expected
// results or an in-testbench archive predictor. Depends on eat_pkg and elitist_archive_table_unit.
`timescale 1ns / 100ps

module elitist_archive_table_unit_tb;
  import eat_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int ARCHIVE_SLOTS = 16;
  localparam int RESET_CYCLES = 6;
  localparam int CFG_SETTLE = 4;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_BLOCKS = 9;
  localparam int BLOCK_ITEMS = 160;
  localparam int KEY_POOL = 20;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         mode;
    logic [9:0]         robot;
    logic [15:0]        generation;
    logic signed [31:0] fitness;
    logic [15:0]        handle;
  } archive_op_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         robot;
    logic [15:0]        generation;
    logic [15:0]        handle;
    logic signed [31:0] fitness;
    logic [4:0]         count;
  } archive_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CAPACITY
  } row_kind_t;

  typedef struct packed {
    row_kind_t       kind;
    logic [4:0]      capacity;
    archive_op_t     op;
    logic            typed;
    archive_result_t want;
  } stim_row_t;

  localparam archive_op_t NO_OP = '0;
  localparam archive_result_t NO_RESULT = '0;
  localparam logic [4:0] CAP_SWEEP [RANDOM_BLOCKS] = '{
    5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd16, 5'd5, 5'd17, 5'd12
  };

  localparam stim_row_t STIM_TABLE [25] = '{
    '{ROW_ITEM, 5'd0, '{MODE_SELECT, 10'd0, 16'd0, 32'sd0, 16'd0},
      1'b1, '{ST_EMPTY, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd0}},
    '{ROW_ITEM, 5'd0, '{MODE_UNUSED, 10'h3ff, 16'hffff, 32'shffffffff, 16'hffff},
      1'b1, '{ST_REJECTED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd0}},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd0, 16'd0, 32'sh80000000, 16'd0},
      1'b1, '{ST_INSERTED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd1}},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'h3ff, 16'hffff, 32'sh7fffffff, 16'hffff},
      1'b1, '{ST_INSERTED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd2}},
    '{ROW_ITEM, 5'd0, '{MODE_SELECT, 10'd0, 16'd0, 32'sd0, 16'd0},
      1'b1, '{ST_BEST, 10'h3ff, 16'hffff, 16'hffff, 32'sh7fffffff, 5'd2}},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd0, 16'd0, 32'sh7fffffff, 16'h1234},
      1'b1, '{ST_UPDATED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd2}},
    '{ROW_ITEM, 5'd0, '{MODE_SELECT, 10'd0, 16'd0, 32'sd0, 16'd0}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd0, 16'd1, 32'sd0, 16'h0005}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_CLEAR, 10'd0, 16'd0, 32'sd0, 16'd0},
      1'b1, '{ST_CLEARED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd0}},
    '{ROW_ITEM, 5'd0, '{MODE_SELECT, 10'd0, 16'd0, 32'sd0, 16'd0},
      1'b1, '{ST_EMPTY, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd0}},
    '{ROW_CAPACITY, 5'd0, NO_OP, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd5, 16'd5, 32'sh000a0000, 16'h00aa},
      1'b1, '{ST_INSERTED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd1}},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd6, 16'd6, 32'sh00050000, 16'h0066},
      1'b1, '{ST_REJECTED, 10'd0, 16'd0, 16'd0, 32'sd0, 5'd1}},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd7, 16'd7, 32'sh000a0000, 16'h0077}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_SELECT, 10'd0, 16'd0, 32'sd0, 16'd0}, 1'b0, NO_RESULT},
    '{ROW_CAPACITY, 5'd2, NO_OP, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd8, 16'd8, 32'shffffffff, 16'h0088}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd9, 16'd9, 32'sh80000000, 16'h0099}, 1'b0, NO_RESULT},
    '{ROW_CAPACITY, 5'd1, NO_OP, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd10, 16'd10, 32'shffffffff, 16'h0100}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd7, 16'd7, 32'sh80000000, 16'd0}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_OFFER, 10'd11, 16'd11, 32'sh80000000, 16'h0111}, 1'b0, NO_RESULT},
    '{ROW_CAPACITY, 5'd31, NO_OP, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_SELECT, 10'd0, 16'd0, 32'sd0, 16'd0}, 1'b0, NO_RESULT},
    '{ROW_ITEM, 5'd0, '{MODE_UNUSED, 10'd0, 16'd0, 32'sd0, 16'd0}, 1'b0, NO_RESULT}
  };

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [4:0]         cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         mode;
  logic [9:0]         sender_robot;
  logic [15:0]        sender_generation;
  logic signed [31:0] offered_fitness;
  logic [15:0]        offered_handle;
  logic               out_valid;
  logic               out_stall;
  logic [2:0]         status;
  logic [9:0]         best_robot;
  logic [15:0]        best_generation;
  logic [15:0]        best_handle;
  logic signed [31:0] best_fitness;
  logic [4:0]         entry_count;

  logic               arc_valid [ARCHIVE_SLOTS];
  logic [9:0]         arc_robot [ARCHIVE_SLOTS];
  logic [15:0]        arc_gen [ARCHIVE_SLOTS];
  logic signed [31:0] arc_fit [ARCHIVE_SLOTS];
  logic [15:0]        arc_handle [ARCHIVE_SLOTS];
  int                 arc_count;
  logic [4:0]         capacity_model;

  archive_result_t    archive_results_due [$];
  logic               typed_row;
  archive_result_t    typed_want;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  bit                 long_hold_req;
  int                 mismatch_count;
  int                 quiet_cycles;

  elitist_archive_table_unit uut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .mode              (mode),
    .sender_robot      (sender_robot),
    .sender_generation (sender_generation),
    .offered_fitness   (offered_fitness),
    .offered_handle    (offered_handle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .best_robot        (best_robot),
    .best_generation   (best_generation),
    .best_handle       (best_handle),
    .best_fitness      (best_fitness),
    .entry_count       (entry_count)
  );

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic archive_result_t archive_predict(archive_op_t op);
    archive_result_t r;
    int lim;
    int pick;
    bit hit;
    r = '0;
    r.status = ST_REJECTED;
    lim = (capacity_model == 5'd0) ? 1 :
          (int'(capacity_model) > ARCHIVE_SLOTS) ? ARCHIVE_SLOTS : int'(capacity_model);
    pick = -1;
    hit = 1'b0;
    case (op.mode)
      MODE_OFFER: begin
        for (int s = 0; s < ARCHIVE_SLOTS; s++) begin
          if (!hit && arc_valid[s] && arc_robot[s] == op.robot &&
              arc_gen[s] == op.generation) begin
            arc_fit[s] = op.fitness;
            hit = 1'b1;
            r.status = ST_UPDATED;
          end
        end
        if (!hit && arc_count < lim) begin
          for (int s = 0; s < ARCHIVE_SLOTS; s++) begin
            if (pick < 0 && !arc_valid[s]) pick = s;
          end
          r.status = ST_INSERTED;
          arc_count++;
        end else if (!hit) begin
          for (int s = 0; s < ARCHIVE_SLOTS; s++) begin
            if (arc_valid[s] && (pick < 0 || arc_fit[s] < arc_fit[pick])) pick = s;
          end
          if (pick >= 0 && arc_fit[pick] <= op.fitness) r.status = ST_REPLACED;
        end
        if (r.status == ST_INSERTED || r.status == ST_REPLACED) begin
          arc_valid[pick] = 1'b1;
          arc_robot[pick] = op.robot;
          arc_gen[pick] = op.generation;
          arc_fit[pick] = op.fitness;
          arc_handle[pick] = op.handle;
        end
      end
      MODE_SELECT: begin
        for (int s = 0; s < ARCHIVE_SLOTS; s++) begin
          if (arc_valid[s] && (pick < 0 || arc_fit[s] > arc_fit[pick])) pick = s;
        end
        if (pick >= 0) begin
          r.status = ST_BEST;
          r.robot = arc_robot[pick];
          r.generation = arc_gen[pick];
          r.handle = arc_handle[pick];
          r.fitness = arc_fit[pick];
        end else begin
          r.status = ST_EMPTY;
        end
      end
      MODE_CLEAR: begin
        for (int s = 0; s < ARCHIVE_SLOTS; s++) arc_valid[s] = 1'b0;
        arc_count = 0;
        r.status = ST_CLEARED;
      end
      default: begin
      end
    endcase
    r.count = arc_count[4:0];
    return r;
  endfunction

  task automatic send_item(archive_op_t op, logic typed, archive_result_t want);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    {mode, sender_robot, sender_generation, offered_fitness, offered_handle} <= op;
    typed_row = typed;
    typed_want = want;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_capacity(logic [4:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    while (archive_results_due.size() != 0) @(negedge clk);
    repeat (CFG_SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    capacity_model = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int hold_left;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        for (hold_left = LONG_HOLD; hold_left > 0; hold_left--) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    archive_op_t taken;
    archive_result_t want;
    archive_result_t seen;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        seen = {status, best_robot, best_generation, best_handle, best_fitness, entry_count};
        if (archive_results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected result transaction, status=%0d count=%0d",
                     $realtime, seen.status, seen.count);
        end else begin
          want = archive_results_due.pop_front();
          if (seen.status !== want.status || seen.robot !== want.robot ||
              seen.generation !== want.generation || seen.handle !== want.handle ||
              seen.fitness !== want.fitness || seen.count !== want.count) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected status=%0d robot=%0d gen=%0d handle=%0d fit=%0d count=%0d",
                       want.status, want.robot, want.generation, want.handle,
                       want.fitness, want.count);
              $display("  actual   status=%0d robot=%0d gen=%0d handle=%0d fit=%0d count=%0d",
                       seen.status, seen.robot, seen.generation, seen.handle,
                       seen.fitness, seen.count);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        taken = {mode, sender_robot, sender_generation, offered_fitness, offered_handle};
        want = archive_predict(taken);
        archive_results_due.insert(archive_results_due.size(), typed_row ? typed_want : want);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    archive_op_t op;
    logic [9:0] pool_robot [KEY_POOL];
    logic [15:0] pool_gen [KEY_POOL];
    int pick;
    int small_fit;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    mode = '0;
    sender_robot = '0;
    sender_generation = '0;
    offered_fitness = '0;
    offered_handle = '0;
    typed_row = 1'b0;
    typed_want = '0;
    long_hold_req = 1'b0;
    mismatch_count = 0;
    quiet_cycles = 0;
    for (int s = 0; s < ARCHIVE_SLOTS; s++) begin
      arc_valid[s] = 1'b0;
      arc_robot[s] = '0;
      arc_gen[s] = '0;
      arc_fit[s] = '0;
      arc_handle[s] = '0;
    end
    arc_count = 0;
    capacity_model = CAPACITY_RESET;
    send_idle_pct = 20;
    recv_stall_pct = 64;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (STIM_TABLE[i]) begin
      if (STIM_TABLE[i].kind == ROW_CAPACITY)
        write_capacity(STIM_TABLE[i].capacity);
      else
        send_item(STIM_TABLE[i].op, STIM_TABLE[i].typed, STIM_TABLE[i].want);
    end

    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      send_idle_pct = (blk / 3 == 0) ? 20 : (blk / 3 == 1) ? 64 : 0;
      recv_stall_pct = (blk / 3 == 0) ? 64 : (blk / 3 == 1) ? 20 : 0;
      write_capacity(blk == RANDOM_BLOCKS - 1 ? 5'($urandom_range(31)) : CAP_SWEEP[blk]);
      for (int k = 0; k < KEY_POOL; k++) begin
        pool_robot[k] = 10'($urandom_range(1023));
        pool_gen[k] = 16'($urandom_range(65535));
      end
      if (blk == 6) long_hold_req = 1'b1;
      for (int n = 0; n < BLOCK_ITEMS; n++) begin
        pick = $urandom_range(99);
        op.mode = (pick < 72) ? MODE_OFFER : (pick < 94) ? MODE_SELECT :
                  (pick < 97) ? MODE_CLEAR : MODE_UNUSED;
        pick = $urandom_range(KEY_POOL - 1);
        op.robot = pool_robot[pick];
        op.generation = pool_gen[pick];
        if ($urandom_range(9) == 0) begin
          op.robot = 10'($urandom_range(1023));
          op.generation = 16'($urandom_range(65535));
        end
        pick = $urandom_range(9);
        small_fit = int'($urandom_range(6)) - 3;
        op.fitness = (pick < 5) ? 32'(small_fit * 65536) :
                     (pick < 8) ? 32'($urandom) :
                     (pick == 8) ? 32'sh80000000 : 32'sh7fffffff;
        op.handle = 16'($urandom_range(65535));
        send_item(op, 1'b0, NO_RESULT);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (archive_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && archive_results_due.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: elitist_archive_table_unit.f
rtl/eat_pkg.sv
rtl/elitist_archive_table_unit.sv
tb/sv/elitist_archive_table_unit_tb.sv
